/* sv/lidar_spherical_to_cartesian_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the lidar point converter
// Clocked property shorthands; reset disables the check.
// -----------------------------------------------------------------------------
`ifndef LIDAR_SPHERICAL_TO_CARTESIAN_MACROS_SVH
`define LIDAR_SPHERICAL_TO_CARTESIAN_MACROS_SVH

// same-cycle implication
`define LSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/lsc_pkg.sv */
// -----------------------------------------------------------------------------
// lsc_pkg
// Widths, register codes, CORDIC constants and rounding helpers.
// -----------------------------------------------------------------------------
package lsc_pkg;

   localparam int RANGE_W     = 15;
   localparam int COORD_W     = 16;
   localparam int INDEX_W     = 10;
   localparam int COUNT_W     = 11;
   localparam int ANGLE_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int RANGE_BITS_DEF = 15;
   localparam int MAX_COLUMNS    = 1024;
   localparam int MAX_ROWS       = 1024;

   localparam logic [COUNT_W-1:0] COL_LIMIT =
      COUNT_W'((MAX_COLUMNS > 1024) ? 1024 : MAX_COLUMNS);
   localparam logic [COUNT_W-1:0] ROW_LIMIT =
      COUNT_W'((MAX_ROWS > 1024) ? 1024 : MAX_ROWS);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_THETA_START  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THETA_STEP   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHI_START    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHI_STEP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_RANGE    = 3'd6;

   localparam logic [ANGLE_W-1:0] THETA_START_RST  = 16'd0;
   localparam logic [ANGLE_W-1:0] THETA_STEP_RST   = 16'd64;
   localparam logic [ANGLE_W-1:0] PHI_START_RST    = 16'd0;
   localparam logic [ANGLE_W-1:0] PHI_STEP_RST     = 16'd64;
   localparam logic [COUNT_W-1:0] COLUMN_COUNT_RST = 11'd682;
   localparam logic [COUNT_W-1:0] ROW_COUNT_RST    = 11'd100;
   localparam logic [RANGE_W-1:0] MIN_RANGE_RST    = 15'd19;

   // CORDIC, Q2.30
   localparam int CORDIC_W     = 32;
   localparam int CORDIC_ITERS = 16;
   localparam int ITER_W       = 4;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

   // shared multiplier
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = 50;

   localparam logic signed [PROD_W-1:0] SAT_HI    = 50'sd32767;
   localparam logic signed [PROD_W-1:0] SAT_LO    = -50'sd32767;
   localparam logic signed [PROD_W-1:0] HALF_Q15  = 50'sd16384;
   localparam logic signed [PROD_W-1:0] HALF_Q30  = 50'sd536870912;

   typedef struct packed {
      logic signed [COORD_W-1:0] cos_v;
      logic signed [COORD_W-1:0] sin_v;
   } trig_type;

   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
      case (i)
         4'd0:    return 32'sd536870912;
         4'd1:    return 32'sd316933406;
         4'd2:    return 32'sd167458907;
         4'd3:    return 32'sd85004757;
         4'd4:    return 32'sd42667331;
         4'd5:    return 32'sd21354465;
         4'd6:    return 32'sd10679840;
         4'd7:    return 32'sd5340245;
         4'd8:    return 32'sd2670163;
         4'd9:    return 32'sd1335087;
         4'd10:   return 32'sd667544;
         4'd11:   return 32'sd333772;
         4'd12:   return 32'sd166886;
         4'd13:   return 32'sd83443;
         4'd14:   return 32'sd41722;
         default: return 32'sd20861;
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
      if (v > SAT_HI) return SAT_HI[COORD_W-1:0];
      if (v < SAT_LO) return SAT_LO[COORD_W-1:0];
      return v[COORD_W-1:0];
   endfunction

   // round half up, then clamp to the symmetric 16-bit range
   function automatic logic signed [COORD_W-1:0] round_q15(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] t;
      t = (v + HALF_Q15) >>> 15;
      return sat16(t);
   endfunction

   function automatic logic signed [COORD_W-1:0] round_q30(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] t;
      t = (v + HALF_Q30) >>> 30;
      return sat16(t);
   endfunction

endpackage

/* sv/lsc_cordic.sv */
// -----------------------------------------------------------------------------
// lsc_cordic
// Iterative rotation CORDIC: cos and sin of a 16-bit binary angle in Q1.15.
// -----------------------------------------------------------------------------
module lsc_cordic (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lsc_pkg::ANGLE_W-1:0]  angle,
   output logic                         done,
   output lsc_pkg::trig_type            result
);
   import lsc_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [CORDIC_W-1:0] sh_x, sh_y, z_start;
   logic [ITER_W-1:0]          iter_ff, iter_in;
   logic                       busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic                       fold_hi, fold_lo, fold;
   logic signed [CORDIC_W:0]   xe, ye, xt, yt;

   // fold into +-90 degrees by flipping the half-circle bit
   assign fold_hi = !angle[15] && angle[14] && (angle[13:0] != 14'd0);
   assign fold_lo = angle[15] && !angle[14];
   assign fold    = fold_hi || fold_lo;
   assign z_start = $signed({angle ^ {fold, 15'd0}, 16'd0});

   assign sh_x = x_ff >>> iter_ff;
   assign sh_y = y_ff >>> iter_ff;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = z_start;
         neg_in  = fold;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - sh_y;
            y_in = y_ff + sh_x;
            z_in = z_ff - atan_q30(iter_ff);
         end else begin
            x_in = x_ff + sh_y;
            y_in = y_ff - sh_x;
            z_in = z_ff + atan_q30(iter_ff);
         end
         iter_in = iter_ff + 4'd1;
         if (iter_ff == ITER_W'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      neg_ff  <= neg_in;
      iter_ff <= iter_in;
   end

   // undo the fold, round to Q1.15
   always_comb begin
      xe = neg_ff ? -$signed({x_ff[CORDIC_W-1], x_ff}) : $signed({x_ff[CORDIC_W-1], x_ff});
      ye = neg_ff ? -$signed({y_ff[CORDIC_W-1], y_ff}) : $signed({y_ff[CORDIC_W-1], y_ff});
      xt = (xe + 33'sd16384) >>> 15;
      yt = (ye + 33'sd16384) >>> 15;
      result.cos_v = sat16(PROD_W'(xt));
      result.sin_v = sat16(PROD_W'(yt));
   end

   assign done = done_ff;

endmodule

/* sv/lidar_spherical_to_cartesian.sv */
// -----------------------------------------------------------------------------
// lidar_spherical_to_cartesian
// Raster range samples in, 3D points out. Each beat on req_ carries one range
// sample in row-major order; the block tracks column and row, derives azimuth
// and elevation from the csr_ start/step registers and returns x, y, z rounded
// to range units with the sample's indices and an end-of-frame flag. A range
// not above min_range returns a zero point with valid_res low. While the rsp_
// side drains, a sample is finished before the next is taken. An invalid one
// goes from idle straight to the output load; a valid one passes a multiply
// step each for the azimuth and elevation angles, two passes of one iterative
// CORDIC unit, four more steps through the shared 33x17 multiplier, a rounding
// step, the output load and the idle state that takes the next beat. A finished
// point waits in the rsp_ register, so a new sample can be taken while it is
// unread; the next finished point then holds the block until the first is
// read. Neither req_ nor csr_ takes a beat during reset. Register writes never
// touch the counters and should be made only while the block is idle.
// -----------------------------------------------------------------------------
module lidar_spherical_to_cartesian #(
   parameter int RANGE_BITS = lsc_pkg::RANGE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lsc_pkg::RANGE_W-1:0]         req_range,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lsc_pkg::COORD_W-1:0]  rsp_x_pos,
   output logic signed [lsc_pkg::COORD_W-1:0]  rsp_y_pos,
   output logic signed [lsc_pkg::COORD_W-1:0]  rsp_z_pos,
   output logic                                rsp_valid_res,
   output logic [lsc_pkg::INDEX_W-1:0]         rsp_row_index,
   output logic [lsc_pkg::INDEX_W-1:0]         rsp_column_index,
   output logic                                rsp_frame_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lsc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import lsc_pkg::*;

   localparam int R_W = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MUL_TH  = 4'd1;
   localparam logic [3:0] ST_MUL_PH  = 4'd2;
   localparam logic [3:0] ST_TRIG_TH = 4'd3;
   localparam logic [3:0] ST_TRIG_PH = 4'd4;
   localparam logic [3:0] ST_MUL_RC  = 4'd5;
   localparam logic [3:0] ST_MUL_Y   = 4'd6;
   localparam logic [3:0] ST_MUL_Z   = 4'd7;
   localparam logic [3:0] ST_MUL_X   = 4'd8;
   localparam logic [3:0] ST_ROUND_X = 4'd9;
   localparam logic [3:0] ST_OUT     = 4'd10;

   logic [3:0] state_ff, state_in;

   // configuration
   logic [ANGLE_W-1:0] theta_start_ff, theta_step_ff, phi_start_ff, phi_step_ff;
   logic [COUNT_W-1:0] column_count_ff, row_count_ff;
   logic [RANGE_W-1:0] min_range_ff;

   // raster position
   logic [INDEX_W-1:0] col_cnt_ff, col_cnt_in, row_cnt_ff, row_cnt_in;
   logic [COUNT_W-1:0] ncols, nrows;
   logic               line_end, frame_end, take, range_ok;

   // item in flight
   logic [R_W-1:0]     r_ff;
   logic [INDEX_W-1:0] col_ff, row_ff;
   logic               valid_ff, last_ff;
   logic [ANGLE_W-1:0] ph_ff;
   trig_type           trig_t_ff, trig_p_ff, trig_res;
   logic signed [PROD_W-1:0]  prod_ff, mul_p;
   logic signed [MUL_A_W-1:0] p_ff, mul_a, r_ext;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic               cordic_start, cordic_done, mul_en;
   logic [ANGLE_W-1:0] cordic_angle;

   // result register
   logic                      rsp_valid_ff, rsp_valid_res_ff, rsp_frame_last_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [INDEX_W-1:0]        rsp_row_ff, rsp_col_ff;
   logic                      rsp_load;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign take      = req_valid && req_ready;
   assign csr_ready = !reset;

   always_comb begin
      if (column_count_ff == '0)          ncols = COUNT_W'(1);
      else if (column_count_ff > COL_LIMIT) ncols = COL_LIMIT;
      else                                ncols = column_count_ff;
      if (row_count_ff == '0)             nrows = COUNT_W'(1);
      else if (row_count_ff > ROW_LIMIT)  nrows = ROW_LIMIT;
      else                                nrows = row_count_ff;
   end

   assign line_end  = ({1'b0, col_cnt_ff} + 11'd1) >= ncols;
   assign frame_end = line_end && (({1'b0, row_cnt_ff} + 11'd1) >= nrows);
   assign range_ok  = RANGE_W'(req_range[R_W-1:0]) > min_range_ff;

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (take) begin
         if (line_end) begin
            col_cnt_in = '0;
            row_cnt_in = frame_end ? '0 : row_cnt_ff + 10'd1;
         end else begin
            col_cnt_in = col_cnt_ff + 10'd1;
         end
      end
   end

   // shared multiplier operand select
   assign r_ext = $signed(MUL_A_W'(r_ff));

   always_comb begin
      mul_a  = r_ext;
      mul_b  = $signed({trig_t_ff.cos_v[COORD_W-1], trig_t_ff.cos_v});
      mul_en = 1'b1;
      case (state_ff)
         ST_MUL_TH: begin
            mul_a = $signed(MUL_A_W'(col_ff));
            mul_b = $signed({1'b0, theta_step_ff});
         end
         ST_MUL_PH: begin
            mul_a = $signed(MUL_A_W'(row_ff));
            mul_b = $signed({1'b0, phi_step_ff});
         end
         ST_MUL_RC: begin
            mul_a = r_ext;
            mul_b = $signed({trig_t_ff.cos_v[COORD_W-1], trig_t_ff.cos_v});
         end
         ST_MUL_Y: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = $signed({trig_p_ff.sin_v[COORD_W-1], trig_p_ff.sin_v});
         end
         ST_MUL_Z: begin
            mul_a = p_ff;
            mul_b = $signed({trig_p_ff.cos_v[COORD_W-1], trig_p_ff.cos_v});
         end
         ST_MUL_X: begin
            mul_a = r_ext;
            mul_b = $signed({trig_t_ff.sin_v[COORD_W-1], trig_t_ff.sin_v});
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // angles are taken mod one turn
   assign cordic_start = (state_ff == ST_MUL_PH) || ((state_ff == ST_TRIG_TH) && cordic_done);
   assign cordic_angle = (state_ff == ST_MUL_PH) ? theta_start_ff + prod_ff[ANGLE_W-1:0]
                                                 : ph_ff;

   lsc_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .angle  (cordic_angle),
      .done   (cordic_done),
      .result (trig_res)
   );

   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (take) state_in = range_ok ? ST_MUL_TH : ST_OUT;
         ST_MUL_TH:  state_in = ST_MUL_PH;
         ST_MUL_PH:  state_in = ST_TRIG_TH;
         ST_TRIG_TH: if (cordic_done) state_in = ST_TRIG_PH;
         ST_TRIG_PH: if (cordic_done) state_in = ST_MUL_RC;
         ST_MUL_RC:  state_in = ST_MUL_Y;
         ST_MUL_Y:   state_in = ST_MUL_Z;
         ST_MUL_Z:   state_in = ST_MUL_X;
         ST_MUL_X:   state_in = ST_ROUND_X;
         ST_ROUND_X: state_in = ST_OUT;
         ST_OUT:     if (rsp_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         col_cnt_ff      <= '0;
         row_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         theta_start_ff  <= THETA_START_RST;
         theta_step_ff   <= THETA_STEP_RST;
         phi_start_ff    <= PHI_START_RST;
         phi_step_ff     <= PHI_STEP_RST;
         column_count_ff <= COLUMN_COUNT_RST;
         row_count_ff    <= ROW_COUNT_RST;
         min_range_ff    <= MIN_RANGE_RST;
      end else begin
         state_ff   <= state_in;
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THETA_START:  theta_start_ff  <= csr_data;
               CSR_THETA_STEP:   theta_step_ff   <= csr_data;
               CSR_PHI_START:    phi_start_ff    <= csr_data;
               CSR_PHI_STEP:     phi_step_ff     <= csr_data;
               CSR_COLUMN_COUNT: column_count_ff <= csr_data[COUNT_W-1:0];
               CSR_ROW_COUNT:    row_count_ff    <= csr_data[COUNT_W-1:0];
               CSR_MIN_RANGE:    min_range_ff    <= csr_data[RANGE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (take) begin
         r_ff     <= req_range[R_W-1:0];
         col_ff   <= col_cnt_ff;
         row_ff   <= row_cnt_ff;
         valid_ff <= range_ok;
         last_ff  <= frame_end;
      end
      if (mul_en)
         prod_ff <= mul_p;
      if (state_ff == ST_TRIG_TH)
         ph_ff <= phi_start_ff + prod_ff[ANGLE_W-1:0];
      if ((state_ff == ST_TRIG_TH) && cordic_done)
         trig_t_ff <= trig_res;
      if ((state_ff == ST_TRIG_PH) && cordic_done)
         trig_p_ff <= trig_res;
      if (state_ff == ST_MUL_Y)
         p_ff <= prod_ff[MUL_A_W-1:0];
      if (state_ff == ST_MUL_Z)
         y_ff <= round_q30(prod_ff);
      if (state_ff == ST_MUL_X)
         z_ff <= round_q30(prod_ff);
      if (state_ff == ST_ROUND_X)
         x_ff <= round_q15(prod_ff);
      if (rsp_load) begin
         rsp_x_ff          <= valid_ff ? x_ff : '0;
         rsp_y_ff          <= valid_ff ? y_ff : '0;
         rsp_z_ff          <= valid_ff ? z_ff : '0;
         rsp_valid_res_ff  <= valid_ff;
         rsp_row_ff        <= row_ff;
         rsp_col_ff        <= col_ff;
         rsp_frame_last_ff <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_x_pos        = rsp_x_ff;
   assign rsp_y_pos        = rsp_y_ff;
   assign rsp_z_pos        = rsp_z_ff;
   assign rsp_valid_res    = rsp_valid_res_ff;
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_frame_last   = rsp_frame_last_ff;

endmodule

/* sv/lsc_checker.sv */
// -----------------------------------------------------------------------------
// lsc_checker
// Port-level checks for the lidar point converter, bound to the top level.
// -----------------------------------------------------------------------------
`include "lidar_spherical_to_cartesian_macros.svh"

module lsc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [lsc_pkg::COORD_W-1:0]  rsp_x_pos,
   input logic signed [lsc_pkg::COORD_W-1:0]  rsp_y_pos,
   input logic signed [lsc_pkg::COORD_W-1:0]  rsp_z_pos,
   input logic                                rsp_valid_res,
   input logic [lsc_pkg::INDEX_W-1:0]         rsp_row_index,
   input logic [lsc_pkg::INDEX_W-1:0]         rsp_column_index,
   input logic                                rsp_frame_last
);
   import lsc_pkg::*;

   // a held beat keeps its payload
   `LSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_x_pos) && $stable(rsp_y_pos) && $stable(rsp_z_pos) && $stable(rsp_row_index) && $stable(rsp_column_index) && $stable(rsp_frame_last), "rsp beat changed while stalled")

   // one sample at a time
   `LSC_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready, "req_ready stayed high after a beat")

   // short ranges give the zero point
   `LSC_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_valid && !rsp_valid_res, rsp_x_pos == 16'sd0 && rsp_y_pos == 16'sd0 && rsp_z_pos == 16'sd0, "invalid point not zero")

   // coordinates are clamped symmetrically
   `LSC_ASSERT_NOW(a_sat_range, clock, reset, rsp_valid, rsp_x_pos != -16'sd32768 && rsp_y_pos != -16'sd32768 && rsp_z_pos != -16'sd32768, "coordinate outside clamp")

endmodule

bind lidar_spherical_to_cartesian lsc_checker u_lsc_checker (.*);

/* verif/lidar_spherical_to_cartesian_tb.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// lidar_spherical_to_cartesian_tb
// Feeds raster range samples through the point converter and checks every
// returned point against a behavioral predictor. The predictor runs the same
// fixed-point CORDIC and rounding as the block and tracks the column/row
// counters itself. A short stimulus table covers the range extremes, the
// invalid-range boundary, degenerate and oversized counts, and counts lowered
// below the running counter. Random register settings and ranges follow, with
// bursty input pacing, output back-pressure and one long output stall.
// -----------------------------------------------------------------------------
module lidar_spherical_to_cartesian_tb;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_ITEMS  = 500;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 100;

   localparam logic [lsc_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   localparam longint GAIN_Q30     = 64'sd652032874;
   localparam longint QUARTER_TURN = 64'sd1073741824;
   localparam longint HALF_TURN    = 64'sd2147483648;
   localparam longint FULL_TURN    = 64'sd4294967296;
   localparam longint ROUND_Q15    = 64'sd16384;
   localparam longint ROUND_Q30    = 64'sd536870912;
   localparam longint COORD_MAX    = 64'sd32767;

   typedef struct packed {
      logic signed [lsc_pkg::COORD_W-1:0] x_pos;
      logic signed [lsc_pkg::COORD_W-1:0] y_pos;
      logic signed [lsc_pkg::COORD_W-1:0] z_pos;
      logic                               valid_res;
      logic [lsc_pkg::INDEX_W-1:0]        row_index;
      logic [lsc_pkg::INDEX_W-1:0]        column_index;
      logic                               frame_last;
   } point_type;

   typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type                        kind;
      logic [lsc_pkg::CSR_INDEX_W-1:0]     reg_index;
      logic [lsc_pkg::CSR_DATA_W-1:0]      reg_data;
      logic [lsc_pkg::RANGE_W-1:0]         range_val;
      logic                                fixed;
      point_type                           fixed_point;
   } stim_row_type;

   typedef enum logic [1:0] {PACE_OPEN, PACE_COIN, PACE_SPARSE, PACE_TOGGLE} pace_mode_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [lsc_pkg::RANGE_W-1:0]         req_range = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [lsc_pkg::COORD_W-1:0]  rsp_x_pos;
   logic signed [lsc_pkg::COORD_W-1:0]  rsp_y_pos;
   logic signed [lsc_pkg::COORD_W-1:0]  rsp_z_pos;
   logic                                rsp_valid_res;
   logic [lsc_pkg::INDEX_W-1:0]         rsp_row_index;
   logic [lsc_pkg::INDEX_W-1:0]         rsp_column_index;
   logic                                rsp_frame_last;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [lsc_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [lsc_pkg::CSR_DATA_W-1:0]      csr_data = '0;

   // predictor copy of the registers and raster counters
   logic [15:0] az_start    = lsc_pkg::THETA_START_RST;
   logic [15:0] az_step     = lsc_pkg::THETA_STEP_RST;
   logic [15:0] el_start    = lsc_pkg::PHI_START_RST;
   logic [15:0] el_step     = lsc_pkg::PHI_STEP_RST;
   logic [10:0] cols_reg    = lsc_pkg::COLUMN_COUNT_RST;
   logic [10:0] rows_reg    = lsc_pkg::ROW_COUNT_RST;
   logic [14:0] floor_range = lsc_pkg::MIN_RANGE_RST;
   logic [9:0]  col_pos     = '0;
   logic [9:0]  row_pos     = '0;

   longint arctan_q30 [16] = '{
      536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
      10679840, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861
   };

   point_type    expected_points [$];
   stim_row_type stim_table [$];
   point_type    no_point = '0;
   int           n_sent = 0;
   int           n_checked = 0;
   int           fails = 0;
   int           burst_left = 0;
   int           cycle_count = 0;

   lidar_spherical_to_cartesian dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_range        (req_range),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_x_pos        (rsp_x_pos),
      .rsp_y_pos        (rsp_y_pos),
      .rsp_z_pos        (rsp_z_pos),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_row_index    (rsp_row_index),
      .rsp_column_index (rsp_column_index),
      .rsp_frame_last   (rsp_frame_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > COORD_MAX) return 16'sd32767;
      if (v < -COORD_MAX) return -16'sd32767;
      return 16'(v);
   endfunction

   // cos/sin of a binary angle, Q1.15; angle folded into +-90 deg first
   function automatic void cordic_trig(input logic [15:0] angle,
                                       output longint cos_q15, output longint sin_q15);
      longint z, x, y, nx;
      bit     flip;
      z = longint'(angle) << 16;
      x = GAIN_Q30;
      y = 0;
      flip = 1'b0;
      if (z >= HALF_TURN) z -= FULL_TURN;
      if (z > QUARTER_TURN) begin
         z -= HALF_TURN;
         flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
         z += HALF_TURN;
         flip = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= arctan_q30[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += arctan_q30[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      cos_q15 = clamp16((x + ROUND_Q15) >>> 15);
      sin_q15 = clamp16((y + ROUND_Q15) >>> 15);
   endfunction

   function automatic int eff_span(input logic [10:0] v, input int cap);
      int lim;
      lim = (cap > 1024) ? 1024 : cap;
      if (v == 0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
   endfunction

   // point for one sample; advances the raster counters
   function automatic point_type convert_sample(input logic [14:0] r);
      point_type   p;
      int          ncols, nrows, col, row;
      bit          line_end, frame_end;
      longint      ct, st, cp, sp, rl;
      logic [15:0] az, el;
      ncols = eff_span(cols_reg, lsc_pkg::MAX_COLUMNS);
      nrows = eff_span(rows_reg, lsc_pkg::MAX_ROWS);
      col = int'(col_pos);
      row = int'(row_pos);
      line_end  = (col + 1) >= ncols;
      frame_end = line_end && ((row + 1) >= nrows);
      p = '0;
      p.valid_res = r > floor_range;
      if (p.valid_res) begin
         az = 16'(int'(az_start) + col * int'(az_step));
         el = 16'(int'(el_start) + row * int'(el_step));
         cordic_trig(az, ct, st);
         cordic_trig(el, cp, sp);
         rl = longint'(r);
         p.x_pos = clamp16((rl * st + ROUND_Q15) >>> 15);
         p.y_pos = clamp16((rl * sp * ct + ROUND_Q30) >>> 30);
         p.z_pos = clamp16((rl * cp * ct + ROUND_Q30) >>> 30);
      end
      p.row_index    = 10'(row);
      p.column_index = 10'(col);
      p.frame_last   = frame_end;
      if (line_end) begin
         col_pos = '0;
         row_pos = frame_end ? 10'd0 : 10'(row + 1);
      end else begin
         col_pos = 10'(col + 1);
      end
      return p;
   endfunction

   function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
      case (idx)
         lsc_pkg::CSR_THETA_START:  az_start = val;
         lsc_pkg::CSR_THETA_STEP:   az_step = val;
         lsc_pkg::CSR_PHI_START:    el_start = val;
         lsc_pkg::CSR_PHI_STEP:     el_step = val;
         lsc_pkg::CSR_COLUMN_COUNT: cols_reg = val[10:0];
         lsc_pkg::CSR_ROW_COUNT:    rows_reg = val[10:0];
         lsc_pkg::CSR_MIN_RANGE:    floor_range = val[14:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- table

   function automatic void add_reg(input logic [2:0] idx, input logic [15:0] val);
      stim_row_type s;
      s = '0;
      s.kind = ROW_REG;
      s.reg_index = idx;
      s.reg_data = val;
      stim_table.insert(stim_table.size(), s);
   endfunction

   function automatic void add_sample(input logic [14:0] r);
      stim_row_type s;
      s = '0;
      s.kind = ROW_SAMPLE;
      s.range_val = r;
      stim_table.insert(stim_table.size(), s);
   endfunction

   // invalid range: zero point, only indices and frame flag to fill in
   function automatic void add_zero(input logic [14:0] r, input int row, input int col,
                                    input logic last);
      stim_row_type s;
      s = '0;
      s.kind = ROW_SAMPLE;
      s.range_val = r;
      s.fixed = 1'b1;
      s.fixed_point.row_index = 10'(row);
      s.fixed_point.column_index = 10'(col);
      s.fixed_point.frame_last = last;
      stim_table.insert(stim_table.size(), s);
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_sample(input logic [14:0] r, input logic fixed,
                              input point_type fixed_point);
      point_type predicted;
      csr_valid <= 1'b0;
      req_valid <= 1'b1;
      req_range <= r;
      do @(posedge clock); while (!req_ready);
      predicted = convert_sample(r);
      expected_points.insert(expected_points.size(), fixed ? fixed_point : predicted);
      n_sent++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (n_checked != n_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pace_gap();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 3)) << 14;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_step();
      case ($urandom_range(0, 4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(1, 4096));
      endcase
   endfunction

   function automatic logic [10:0] pick_count(input int short_max);
      case ($urandom_range(0, 9))
         0:       return 11'd0;
         1:       return 11'd1024;
         2:       return 11'($urandom_range(1025, 2047));
         3:       return 11'($urandom_range(1, 1023));
         default: return 11'($urandom_range(1, short_max));
      endcase
   endfunction

   function automatic logic [14:0] pick_min_range();
      case ($urandom_range(0, 7))
         0:       return 15'd0;
         1:       return 15'd32767;
         2:       return 15'($urandom_range(0, 32767));
         default: return 15'($urandom_range(0, 60));
      endcase
   endfunction

   function automatic logic [14:0] pick_range();
      int top;
      top = int'(floor_range) + 2000;
      if (top > 32767) top = 32767;
      case ($urandom_range(0, 9))
         0:       return 15'd0;
         1:       return 15'd32767;
         2:       return floor_range;
         3:       return (floor_range == 15'd32767) ? floor_range : floor_range + 15'd1;
         4, 5:    return 15'($urandom_range(0, 32767));
         default: return 15'($urandom_range(int'(floor_range), top));
      endcase
   endfunction

   // upper data bits above each register's width are junk and must be dropped
   task automatic random_config();
      wait_idle();
      write_reg(lsc_pkg::CSR_THETA_START, pick_angle());
      write_reg(lsc_pkg::CSR_THETA_STEP, pick_step());
      write_reg(lsc_pkg::CSR_PHI_START, pick_angle());
      write_reg(lsc_pkg::CSR_PHI_STEP, pick_step());
      write_reg(lsc_pkg::CSR_COLUMN_COUNT, {5'($urandom), pick_count(12)});
      write_reg(lsc_pkg::CSR_ROW_COUNT, {5'($urandom), pick_count(6)});
      write_reg(lsc_pkg::CSR_MIN_RANGE, {1'($urandom), pick_min_range()});
      if ($urandom_range(0, 3) == 0) write_reg(CSR_SPARE, 16'($urandom));
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      int n_random, batch;
      // reset settings: 682 columns, 100 rows, min range 19
      add_zero(15'd0, 0, 0, 1'b0);
      add_zero(15'd19, 0, 1, 1'b0);
      add_sample(15'd20);
      add_sample(15'd32767);
      add_sample(15'h5555);
      add_sample(15'h2AAA);
      // quarter-turn azimuth steps, elevation near the wrap; column counter (6)
      // is now past the 3-column count
      add_reg(lsc_pkg::CSR_THETA_START, 16'hC000);
      add_reg(lsc_pkg::CSR_THETA_STEP, 16'h4000);
      add_reg(lsc_pkg::CSR_PHI_START, 16'hFFFF);
      add_reg(lsc_pkg::CSR_PHI_STEP, 16'h8000);
      add_reg(lsc_pkg::CSR_COLUMN_COUNT, 16'hF803);
      add_reg(lsc_pkg::CSR_ROW_COUNT, 16'h0002);
      add_reg(lsc_pkg::CSR_MIN_RANGE, 16'h0000);
      add_sample(15'd1);
      add_sample(15'd32767);
      add_sample(15'd32767);
      add_sample(15'd32767);
      add_zero(15'd0, 0, 0, 1'b0);
      add_sample(15'd16384);
      add_sample(15'd100);
      // zero counts act as one: every sample closes a frame; nothing is valid
      add_reg(lsc_pkg::CSR_COLUMN_COUNT, 16'h0000);
      add_reg(lsc_pkg::CSR_ROW_COUNT, 16'h0000);
      add_reg(lsc_pkg::CSR_MIN_RANGE, 16'h7FFF);
      add_reg(CSR_SPARE, 16'hFFFF);
      add_reg(lsc_pkg::CSR_THETA_START, 16'hFFFF);
      add_reg(lsc_pkg::CSR_THETA_STEP, 16'hFFFF);
      add_reg(lsc_pkg::CSR_PHI_START, 16'h8000);
      add_reg(lsc_pkg::CSR_PHI_STEP, 16'hFFFF);
      add_zero(15'd32767, 1, 0, 1'b1);
      add_zero(15'd0, 0, 0, 1'b1);
      add_zero(15'h4321, 0, 0, 1'b1);
      // oversized counts clip to the limit
      add_reg(lsc_pkg::CSR_COLUMN_COUNT, 16'h07FF);
      add_reg(lsc_pkg::CSR_ROW_COUNT, 16'h0400);
      add_reg(lsc_pkg::CSR_MIN_RANGE, 16'h7FFE);
      add_sample(15'd32767);
      add_zero(15'd32766, 0, 1, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_REG) begin
            if (i == 0 || stim_table[i-1].kind != ROW_REG) wait_idle();
            write_reg(stim_table[i].reg_index, stim_table[i].reg_data);
         end else begin
            send_sample(stim_table[i].range_val, stim_table[i].fixed,
                        stim_table[i].fixed_point);
            pace_gap();
         end
      end

      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         random_config();
         batch = $urandom_range(40, 70);
         repeat (batch) begin
            send_sample(pick_range(), 1'b0, no_point);
            pace_gap();
         end
         n_random += batch;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_points.size() != 0) begin
         $error("%0d points never returned", expected_points.size());
         fails++;
      end
      if (fails == 0)
         $display("PASS lidar_spherical_to_cartesian");
      else
         $display("FAIL lidar_spherical_to_cartesian");
      $finish;
   end

   // output back-pressure; one long stall lets the block fill and block req_
   initial begin : sink_pacing
      pace_mode_type mode;
      int            left;
      bit            hold_done;
      mode = PACE_OPEN;
      left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && n_checked >= 60) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (left == 0) begin
            mode = pace_mode_type'($urandom_range(0, 3));
            left = $urandom_range(8, 80);
         end
         left--;
         case (mode)
            PACE_OPEN:   rsp_ready <= 1'b1;
            PACE_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            PACE_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   // ---------------------------------------------------------------- checker

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : point_check
      point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $error("point beat with no sample outstanding: row %0d col %0d",
                   rsp_row_index, rsp_column_index);
            fails++;
         end else begin
            want = expected_points.pop_front();
            n_checked++;
            compare_field("x_pos", want.x_pos, rsp_x_pos);
            compare_field("y_pos", want.y_pos, rsp_y_pos);
            compare_field("z_pos", want.z_pos, rsp_z_pos);
            compare_field("valid_res", want.valid_res, rsp_valid_res);
            compare_field("row_index", want.row_index, rsp_row_index);
            compare_field("column_index", want.column_index, rsp_column_index);
            compare_field("frame_last", want.frame_last, rsp_frame_last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL lidar_spherical_to_cartesian");
         $finish;
      end
   end

endmodule

/* filelist.f */
+incdir+sv
sv/lsc_pkg.sv
sv/lsc_cordic.sv
sv/lidar_spherical_to_cartesian.sv
sv/lsc_checker.sv
verif/lidar_spherical_to_cartesian_tb.sv
